@@ design/spq_pkg.sv @@
// Package for the sorted priority queue.
// Holds the command and status codes and the request and result item types.
// No dependencies.
package spq_pkg;

    // Operation carried by a request item.
    typedef enum logic [0:0] {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } command_t;

    // Outcome reported with every result item.
    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DEQUEUED = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed {
        command_t           command;
        logic signed [31:0] item_value;
        logic signed [15:0] item_priority;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] head_value;
        logic signed [15:0] head_priority;
        logic        [4:0]  occupancy;
    } result_t;

endpackage

@@ design/sorted_priority_queue.sv @@
// Sorted priority queue: a row of registered cells, highest priority at cell 0.
// Latency: the result item appears on result, marked by done, in the cycle after acceptance.
// Throughput: one item per cycle; busy stays low.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset empties the queue and clears done; cell contents are left as they were.
// Depends on spq_pkg.
module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::request_t request,
    output logic              done,
    output spq_pkg::result_t  result
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [31:0] val_reg  [CAPACITY];
    logic signed [15:0] pri_reg  [CAPACITY];
    logic signed [31:0] val_next [CAPACITY];
    logic signed [15:0] pri_next [CAPACITY];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    result_t            result_reg;
    result_t            result_next;

    logic [CAPACITY-1:0] ge;
    logic                accept;
    logic                full;
    logic                empty;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);

    // Each cell checks whether the new item belongs at or ahead of it.
    // Cells past the count always qualify, so the vector is a run of zeros then ones.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (CNT_W'(i) < count_reg)
                ge[i] = (request.item_priority >= pri_reg[i]);
            else
                ge[i] = 1'b1;
        end
    end

    // Next cell contents, count and result item.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
        end
        count_next                = count_reg;
        result_next.status        = ST_ENQUEUED;
        result_next.head_value    = '0;
        result_next.head_priority = '0;

        unique case (request.command)
            CMD_ENQUEUE:
            begin
                if (full)
                begin
                    result_next.status = ST_FULL;
                end
                else
                begin
                    // Cell 0 takes the new item when it qualifies.
                    if (ge[0])
                    begin
                        val_next[0] = request.item_value;
                        pri_next[0] = request.item_priority;
                    end
                    // Other cells take the new item at the boundary, or shift down past it.
                    for (int i = 1; i < CAPACITY; i++)
                    begin
                        if (ge[i] && !ge[i-1])
                        begin
                            val_next[i] = request.item_value;
                            pri_next[i] = request.item_priority;
                        end
                        else if (ge[i])
                        begin
                            val_next[i] = val_reg[i-1];
                            pri_next[i] = pri_reg[i-1];
                        end
                    end
                    count_next         = count_reg + CNT_W'(1);
                    result_next.status = ST_ENQUEUED;
                end
            end
            CMD_DEQUEUE:
            begin
                if (empty)
                begin
                    result_next.status = ST_EMPTY;
                end
                else
                begin
                    // Hand out the head and move every cell but the last up by one.
                    result_next.head_value    = val_reg[0];
                    result_next.head_priority = pri_reg[0];
                    for (int i = 0; i < CAPACITY - 1; i++)
                    begin
                        val_next[i] = val_reg[i+1];
                        pri_next[i] = pri_reg[i+1];
                    end
                    count_next         = count_reg - CNT_W'(1);
                    result_next.status = ST_DEQUEUED;
                end
            end
            default:
            begin
                result_next.status = ST_EMPTY;
            end
        endcase
        result_next.occupancy = 5'(count_next);
    end

    // Cell storage and the result payload carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                val_reg[i] <= val_next[i];
                pri_reg[i] <= pri_next[i];
            end
            result_reg <= result_next;
        end
    end

    // Control state: entry count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
                count_reg <= count_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted item yields a result in the next cycle, and only then.
    assert property (@(posedge clk) disable iff (!rst_n) accept |=> done)
        else $error("accepted item produced no result");
    assert property (@(posedge clk) disable iff (!rst_n) !accept |=> !done)
        else $error("result strobe without an accepted item");

    // The count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // Reported occupancy matches the held count.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.occupancy == 5'(count_reg)))
        else $error("occupancy disagrees with entry count");

    // Only a successful dequeue returns a nonzero head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_DEQUEUED))
        |-> (result.head_value == '0 && result.head_priority == '0))
        else $error("head fields nonzero without a dequeue");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the sorted priority queue.
// Runs a directed table and then random enqueue and dequeue items against a predictor.
// Depends on spq_pkg and sorted_priority_queue.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int DEPTH          = 16;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int STALL_LIMIT    = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int IDLE_PERCENT   = 19;
    localparam int STEADY_FIRST   = 700;
    localparam int STEADY_LAST    = 1000;

    // One row of the directed stimulus; want is used only when pinned is set.
    typedef struct {
        request_t req;
        bit       pinned;
        result_t  want;
    } plan_row_t;

    logic     clk          = 1'b0;
    logic     rst_n        = 1'b0;
    logic     start        = 1'b0;
    request_t request      = '0;
    logic     pinned_flag  = 1'b0;
    result_t  pinned_value = '0;
    logic     busy;
    logic     done;
    result_t  result;

    // Predictor state: the held entries, highest priority first.
    logic signed [31:0] held_values [DEPTH];
    logic signed [15:0] held_priorities [DEPTH];
    int                 held_count = 0;

    result_t   expected_results [$];
    plan_row_t plan [$];
    int        error_count = 0;
    int        stall_cycles = 0;

    sorted_priority_queue #(
        .CAPACITY(DEPTH)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    always #5 clk = ~clk;

    // Applies one item to the predicted queue and returns the result it causes.
    function automatic result_t queue_model_step(request_t req);
        result_t res;
        int      pos;
        res = '0;
        if (req.command == CMD_ENQUEUE) begin
            if (held_count >= DEPTH) begin
                res.status = ST_FULL;
            end
            else begin
                pos = 0;
                while (pos < held_count && req.item_priority < held_priorities[pos])
                    pos++;
                for (int i = held_count; i > pos; i--) begin
                    held_values[i]     = held_values[i - 1];
                    held_priorities[i] = held_priorities[i - 1];
                end
                held_values[pos]     = req.item_value;
                held_priorities[pos] = req.item_priority;
                held_count++;
                res.status = ST_ENQUEUED;
            end
        end
        else begin
            if (held_count == 0) begin
                res.status = ST_EMPTY;
            end
            else begin
                res.head_value    = held_values[0];
                res.head_priority = held_priorities[0];
                for (int i = 0; i + 1 < held_count; i++) begin
                    held_values[i]     = held_values[i + 1];
                    held_priorities[i] = held_priorities[i + 1];
                end
                held_count--;
                res.status = ST_DEQUEUED;
            end
        end
        res.occupancy = 5'(held_count);
        return res;
    endfunction

    function automatic void plan_checked(command_t c, logic [31:0] v, logic [15:0] p);
        plan_row_t row;
        row.req    = '{command: c, item_value: v, item_priority: p};
        row.pinned = 1'b0;
        row.want   = '0;
        plan.push_back(row);
    endfunction

    function automatic void plan_pinned(command_t c, logic [31:0] v, logic [15:0] p,
                                        status_t s, logic [31:0] hv, logic [15:0] hp,
                                        logic [4:0] occ);
        plan_row_t row;
        row.req    = '{command: c, item_value: v, item_priority: p};
        row.pinned = 1'b1;
        row.want   = '{status: s, head_value: hv, head_priority: hp, occupancy: occ};
        plan.push_back(row);
    endfunction

    // Presents one item and holds it until the queue takes it.
    task automatic send_item(request_t req, bit pinned, result_t want, bit may_idle);
        start        <= 1'b1;
        request      <= req;
        pinned_flag  <= pinned;
        pinned_value <= want;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (may_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Priority mix: many near-equal values for ties, some extremes, the rest anywhere.
    function automatic logic [15:0] pick_priority();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return 16'($signed($urandom_range(0, 8)) - 4);
        else if (sel == 4)
            return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        else
            return 16'($urandom);
    endfunction

    // Record each accepted item and its predicted result.
    always @(posedge clk) begin
        result_t predicted;
        if (rst_n && start && !busy) begin
            predicted = queue_model_step(request);
            if (pinned_flag)
                predicted = pinned_value;
            expected_results.push_back(predicted);
        end
    end

    // Compare each result item with the oldest prediction.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && done === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result item arrived with no item outstanding");
                error_count++;
            end
            else begin
                want = expected_results.pop_front();
                if (result.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, result.status);
                    error_count++;
                end
                if (result.head_value !== want.head_value) begin
                    $error("head_value: expected %0d, got %0d",
                           want.head_value, result.head_value);
                    error_count++;
                end
                if (result.head_priority !== want.head_priority) begin
                    $error("head_priority: expected %0d, got %0d",
                           want.head_priority, result.head_priority);
                    error_count++;
                end
                if (result.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           want.occupancy, result.occupancy);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which nothing moves.
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done === 1'b1) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // Stimulus and end of run.
    initial begin
        request_t req;
        result_t  none;
        int       enqueue_percent;
        none = '0;

        // Empty queue, extremes, a tie and the draining order.
        plan_pinned(CMD_DEQUEUE, 32'h1234_5678, 16'h7fff, ST_EMPTY, 32'h0, 16'h0, 5'd0);
        plan_pinned(CMD_ENQUEUE, 32'h7fff_ffff, 16'h7fff, ST_ENQUEUED, 32'h0, 16'h0, 5'd1);
        plan_pinned(CMD_ENQUEUE, 32'h8000_0000, 16'h8000, ST_ENQUEUED, 32'h0, 16'h0, 5'd2);
        plan_pinned(CMD_ENQUEUE, 32'h0000_0000, 16'h0000, ST_ENQUEUED, 32'h0, 16'h0, 5'd3);
        plan_pinned(CMD_ENQUEUE, 32'hffff_ffff, 16'h0000, ST_ENQUEUED, 32'h0, 16'h0, 5'd4);
        plan_pinned(CMD_DEQUEUE, 32'h0, 16'h0,
                    ST_DEQUEUED, 32'h7fff_ffff, 16'h7fff, 5'd3);
        plan_pinned(CMD_DEQUEUE, 32'hffff_ffff, 16'hffff,
                    ST_DEQUEUED, 32'hffff_ffff, 16'h0000, 5'd2);
        plan_pinned(CMD_DEQUEUE, 32'h0, 16'h0, ST_DEQUEUED, 32'h0, 16'h0, 5'd1);
        plan_pinned(CMD_DEQUEUE, 32'h0, 16'h0,
                    ST_DEQUEUED, 32'h8000_0000, 16'h8000, 5'd0);
        plan_pinned(CMD_DEQUEUE, 32'h0, 16'h0, ST_EMPTY, 32'h0, 16'h0, 5'd0);
        // Fill to capacity with mixed-sign priorities, then one enqueue too many.
        for (int i = 0; i < DEPTH; i++)
            plan_checked(CMD_ENQUEUE, 32'(i) * 32'h1111_1111 ^ 32'ha5a5_0000,
                         (i % 3 == 0) ? 16'hffff : (i % 3 == 1) ? 16'h0001 : 16'(16'h8000 + i));
        plan_pinned(CMD_ENQUEUE, 32'h5a5a_5a5a, 16'h7fff, ST_FULL, 32'h0, 16'h0, 5'd16);
        plan_checked(CMD_DEQUEUE, 32'h0, 16'h0);
        plan_checked(CMD_DEQUEUE, 32'h0, 16'h0);

        // Reset is held from the start, then released once.
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            send_item(plan[i].req, plan[i].pinned, plan[i].want, 1'b1);

        // Random part: the enqueue share changes every fifty items so the
        // occupancy sweeps between empty and full.
        enqueue_percent = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                case ($urandom_range(0, 3))
                    0:       enqueue_percent = 20;
                    1:       enqueue_percent = 50;
                    2:       enqueue_percent = 75;
                    default: enqueue_percent = 95;
                endcase
            end
            req.command       = ($urandom_range(0, 99) < enqueue_percent) ?
                                CMD_ENQUEUE : CMD_DEQUEUE;
            req.item_value    = $urandom;
            req.item_priority = pick_priority();
            send_item(req, 1'b0, none, !(n >= STEADY_FIRST && n < STEADY_LAST));
        end
        start <= 1'b0;

        // Drain: wait for every predicted result, then idle before the end of the run.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
